>>> hw/rtl/tdf_pkg.sv
package tdf_pkg;

  localparam int unsigned NUMBER_BITS = 32;

  typedef struct packed {
    logic                   op;
    logic [NUMBER_BITS-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] factor;
    logic                   no_factors;
    logic                   last;
  } out_item_t;

endpackage

>>> hw/rtl/trial_division_factorizer.sv
// Trial-division prime factorizer.
// An item on the input channel (in_valid_i, in_ready_o, in_item_i) carries a
// number and a mode bit. The block returns the prime factors of the number,
// with multiplicity, one item per factor on the output channel (out_valid_o,
// out_ready_i, out_item_o), and marks the final one with last. Mode 0 returns
// the largest factor first and mode 1 the smallest first. A number below two
// gives a single item with no_factors set and a zero factor.
// Every trial divisor costs one pass of the bit-serial divider, so the time
// for an item grows with the number of trial divisors tested, up to roughly
// 65536 divisors for a 32-bit number; each factor returned then passes
// through the S_WAIT and S_LOAD states.
// One item is factored at a time; in_ready_o is high only while the block is
// idle. The last result sits in an output register, so the next item is
// accepted while that result still waits. A stalled receiver holds the block
// in S_TRIV or S_LOAD with the current result unchanged. Reset empties the
// output register and returns the block to idle; no clearing pass is needed.
module trial_division_factorizer #(
  parameter int unsigned MAX_FACTORS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tdf_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tdf_pkg::out_item_t   out_item_o
);

  localparam int unsigned NB   = tdf_pkg::NUMBER_BITS;
  localparam int unsigned AW   = $clog2(MAX_FACTORS);
  localparam int unsigned CNTW = $clog2(MAX_FACTORS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIV,
    S_DIV,
    S_DIVW,
    S_WAIT,
    S_LOAD
  } state_e;

  state_e             state_q;
  logic               op_q;
  logic [NB-1:0]      rem_q;
  logic [NB-1:0]      dvs_q;
  logic [CNTW-1:0]    cnt_q;
  logic [CNTW-1:0]    k_q;
  logic [AW-1:0]      raddr_q;
  logic               out_valid_q;
  tdf_pkg::out_item_t out_item_q;

  logic               div_start;
  logic               div_done;
  logic [NB-1:0]      div_quot;
  logic [NB-1:0]      div_rem;

  logic               ram_we;
  logic [NB-1:0]      ram_wdata;
  logic [NB-1:0]      ram_rdata;
  logic               room;
  logic               keep_going;
  logic [CNTW-1:0]    cnt_d;
  logic [CNTW-1:0]    first_src;
  logic [CNTW-1:0]    next_src;
  logic               out_free;
  logic               out_load;
  logic               is_last;

  always_comb begin
    div_start  = (state_q == S_DIV);
    room       = cnt_q < CNTW'(MAX_FACTORS);
    keep_going = dvs_q <= div_quot;
    ram_we     = 1'b0;
    ram_wdata  = dvs_q;
    if (state_q == S_DIVW && div_done) begin
      if (keep_going) begin
        ram_we = (div_rem == '0) && room;
      end else begin
        ram_we    = (rem_q > NB'(1)) && room;
        ram_wdata = rem_q;
      end
    end
    cnt_d     = cnt_q + CNTW'(ram_we);
    first_src = op_q ? '0 : cnt_d - 1'b1;
    next_src  = op_q ? k_q + 1'b1 : cnt_q - k_q - CNTW'(2);
    out_free  = !out_valid_q || out_ready_i;
    out_load  = ((state_q == S_TRIV) || (state_q == S_LOAD)) && out_free;
    is_last   = (k_q + 1'b1) == cnt_q;
  end

  tdf_divider #(
    .WIDTH(NB)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rem_q),
    .divisor_i   (dvs_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  tdf_ram #(
    .WIDTH(NB),
    .DEPTH(MAX_FACTORS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= 1'b0;
      rem_q       <= '0;
      dvs_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      raddr_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= in_item_i.op;
            rem_q <= in_item_i.number;
            dvs_q <= NB'(2);
            cnt_q <= '0;
            k_q   <= '0;
            state_q <= (in_item_i.number < NB'(2)) ? S_TRIV : S_DIV;
          end
        end
        S_TRIV: begin
          if (out_free) begin
            out_item_q.factor     <= '0;
            out_item_q.no_factors <= 1'b1;
            out_item_q.last       <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        S_DIV: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            cnt_q <= cnt_d;
            if (keep_going) begin
              if (div_rem == '0) begin
                rem_q <= div_quot;
              end else begin
                dvs_q <= dvs_q + 1'b1;
              end
              state_q <= S_DIV;
            end else begin
              raddr_q <= first_src[AW-1:0];
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_item_q.factor     <= ram_rdata;
            out_item_q.no_factors <= 1'b0;
            out_item_q.last       <= is_last;
            k_q                   <= k_q + 1'b1;
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              raddr_q <= next_src[AW-1:0];
              state_q <= S_WAIT;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hw/rtl/tdf_ram.sv
module tdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tdf_divider.sv
module tdf_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] quot_q;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quot_q[WIDTH-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
        rem_q  <= '0;
        quot_q <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quot_q <= {quot_q[WIDTH-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

>>> verif/trial_division_factorizer_tb.sv
`timescale 1ns / 100ps

module trial_division_factorizer_tb;

  localparam logic OP_LARGEST_FIRST  = 1'b0;
  localparam logic OP_SMALLEST_FIRST = 1'b1;
  localparam int   FACTOR_SLOTS      = 32;

  class factor_ledger;
    tdf_pkg::out_item_t expected_factors[$];
    int                 errors = 0;

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function int pending();
      return expected_factors.size();
    endfunction

    function void note_number(tdf_pkg::in_item_t it);
      longint unsigned rest;
      longint unsigned divisor;
      logic [tdf_pkg::NUMBER_BITS-1:0] primes[$];
      tdf_pkg::out_item_t entry;
      int count;
      if (it.number < 2) begin
        entry.factor = '0;
        entry.no_factors = 1'b1;
        entry.last = 1'b1;
        expected_factors.push_back(entry);
        return;
      end
      rest = it.number;
      divisor = 2;
      while (divisor <= rest / divisor) begin
        if (rest % divisor == 0) begin
          if (primes.size() < FACTOR_SLOTS) begin
            primes.push_back(divisor[tdf_pkg::NUMBER_BITS-1:0]);
          end
          rest = rest / divisor;
        end else begin
          divisor++;
        end
      end
      if (rest > 1 && primes.size() < FACTOR_SLOTS) begin
        primes.push_back(rest[tdf_pkg::NUMBER_BITS-1:0]);
      end
      count = primes.size();
      for (int k = 0; k < count; k++) begin
        entry.factor = (it.op == OP_LARGEST_FIRST) ? primes[count - 1 - k] : primes[k];
        entry.no_factors = 1'b0;
        entry.last = (k == count - 1);
        expected_factors.push_back(entry);
      end
    endfunction

    task check_factor(tdf_pkg::out_item_t got);
      tdf_pkg::out_item_t want;
      if (expected_factors.size() == 0) begin
        report($sformatf("unexpected item factor=%0d no_factors=%0b last=%0b",
                         got.factor, got.no_factors, got.last));
        return;
      end
      want = expected_factors.pop_front();
      if (got.factor !== want.factor) begin
        report($sformatf("factor got %0d want %0d", got.factor, want.factor));
      end
      if (got.no_factors !== want.no_factors) begin
        report($sformatf("no_factors got %0b want %0b", got.no_factors, want.no_factors));
      end
      if (got.last !== want.last) begin
        report($sformatf("last got %0b want %0b (factor %0d)", got.last, want.last,
                         want.factor));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tdf_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tdf_pkg::out_item_t out_item;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  factor_ledger ledger = new();

  trial_division_factorizer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_factor(out_item);
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [tdf_pkg::NUMBER_BITS-1:0] number);
    tdf_pkg::in_item_t it;
    it.op = op;
    it.number = number;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    ledger.note_number(it);
  endtask

  // Most numbers are a cofactor up to ten thousand times factors from two to
  // 97, so the divisor search stays short while the value can span all bits.
  function automatic logic [tdf_pkg::NUMBER_BITS-1:0] pick_number();
    longint unsigned v;
    longint unsigned f;
    int shape;
    shape = $urandom_range(0, 99);
    if (shape < 6) return $urandom_range(0, 3);
    v = $urandom_range(2, 10000);
    do begin
      f = $urandom_range(2, 97);
      if (v * f > 64'hFFFF_FFFF) break;
      v = v * f;
    end while (shape < 30 || $urandom_range(0, 4) != 0);
    return v[tdf_pkg::NUMBER_BITS-1:0];
  endfunction

  initial begin
    logic [tdf_pkg::NUMBER_BITS-1:0] directed[$];
    int phase_idle[4];
    int phase_stall[4];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd12, 32'd49, 32'd97, 32'd10403,
                 32'd65521, 32'd999983, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF,
                 32'hFFFE_0001};
    phase_idle = '{0, 86, 0, 11};
    phase_stall = '{0, 0, 86, 11};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_item((i % 2 == 0) ? OP_LARGEST_FIRST : OP_SMALLEST_FIRST, directed[i]);
    end
    send_item(OP_LARGEST_FIRST, 32'd1);
    send_item(OP_SMALLEST_FIRST, 32'd12);
    send_item(OP_LARGEST_FIRST, 32'd999983);
    send_item(OP_SMALLEST_FIRST, 32'h8000_0000);
    send_item(OP_LARGEST_FIRST, 32'hFFFF_FFFF);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (25) send_item(1'($urandom_range(0, 1)), pick_number());
    end

    // The receiver stops for a long time while items keep coming, so the
    // block backs up and must hold off its input.
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 3000;
    send_item(OP_SMALLEST_FIRST, 32'h8000_0000);
    repeat (4) send_item(1'($urandom_range(0, 1)), pick_number());

    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (ledger.pending() != 0) ledger.report("expected items left over at the end");
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_ram.sv
hw/rtl/tdf_divider.sv
hw/rtl/trial_division_factorizer.sv
verif/trial_division_factorizer_tb.sv
